// ===== hw/rtl/ttl_pkg.sv =====
// Shared types and constants for the token expiry table.
// Used by the channel interfaces, the table cell, the controller and the top level.
package ttl_pkg;

   localparam int CMD_W    = 2;
   localparam int KEY_W    = 64;
   localparam int TIME_W   = 32;
   localparam int TTL_W    = 31;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_GENERATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RENEW    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COUNT    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RENEW_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd2;

   localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TTL_W-1:0]   TTL_RESET = 31'd5;

   // Item under work, broadcast to every cell.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] expiry;
   } op_type;

   // Token walking the cell chain. In the scan pass flag means a live match was
   // seen; in the commit pass it means an insert is still pending.
   typedef struct packed {
      logic               valid;
      logic               commit;
      logic               flag;
      logic [COUNT_W-1:0] count;
   } tok_type;

endpackage

// ===== hw/rtl/ttl_req_if.sv =====
// Request channel interface: valid/ready handshake with command, key and time.
// Depends on ttl_pkg.
interface ttl_req_if;
   logic                       valid;
   logic                       ready;
   logic [ttl_pkg::CMD_W-1:0]  cmd;
   logic [ttl_pkg::KEY_W-1:0]  token_key;
   logic [ttl_pkg::TIME_W-1:0] current_time;

   modport source (output valid, output cmd, output token_key, output current_time,
                   input ready);
   modport sink   (input valid, input cmd, input token_key, input current_time,
                   output ready);
endinterface

// ===== hw/rtl/ttl_rsp_if.sv =====
// Response channel interface: valid/ready handshake with live count and status.
// Depends on ttl_pkg.
interface ttl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ttl_pkg::COUNT_W-1:0]  live_count;
   logic [ttl_pkg::STATUS_W-1:0] status;

   modport source (output valid, output live_count, output status, input ready);
   modport sink   (input valid, input live_count, input status, output ready);
endinterface

// ===== hw/rtl/ttl_cell.sv =====
// One table entry of the token chain: holds valid, key and expiry, sweeps,
// matches, inserts and counts as the token passes. Depends on ttl_pkg.
module ttl_cell (
   input  logic             clock,
   input  logic             reset,
   input  ttl_pkg::op_type  op,
   input  ttl_pkg::tok_type tok_in,
   output ttl_pkg::tok_type tok_out
);

   logic                       valid_ff, valid_in;
   logic [ttl_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [ttl_pkg::TIME_W-1:0] expiry_ff, expiry_in;
   ttl_pkg::tok_type           tok_ff, tok_in_next;

   logic live_now;
   logic key_hit;
   logic counted;

   assign live_now = valid_ff && (expiry_ff > op.now);
   assign key_hit  = live_now && (key_ff == op.key);

   always_comb begin
      valid_in    = valid_ff;
      key_in      = key_ff;
      expiry_in   = expiry_ff;
      tok_in_next = tok_in;
      counted     = 1'b0;
      if (tok_in.valid && !tok_in.commit) begin
         valid_in = live_now;
         if (key_hit && !tok_in.flag &&
             (op.cmd == ttl_pkg::CMD_GENERATE || op.cmd == ttl_pkg::CMD_RENEW)) begin
            expiry_in = op.expiry;
         end
         tok_in_next.flag = tok_in.flag | key_hit;
      end else if (tok_in.valid && tok_in.commit) begin
         if (tok_in.flag && !valid_ff) begin
            valid_in         = 1'b1;
            key_in           = op.key;
            expiry_in        = op.expiry;
            tok_in_next.flag = 1'b0;
            counted          = op.expiry > op.now;
         end else begin
            counted = live_now;
         end
         if (counted && tok_in.count != ttl_pkg::COUNT_MAX) begin
            tok_in_next.count = tok_in.count + ttl_pkg::COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         tok_ff.valid <= tok_in_next.valid;
      end
      key_ff        <= key_in;
      expiry_ff     <= expiry_in;
      tok_ff.commit <= tok_in_next.commit;
      tok_ff.flag   <= tok_in_next.flag;
      tok_ff.count  <= tok_in_next.count;
   end

   assign tok_out = tok_ff;

endmodule

// ===== hw/rtl/ttl_ctrl.sv =====
// Sequencer for the token chain: takes request items, launches the scan and
// commit tokens, builds the result and holds it in the output register. Depends on ttl_pkg.
module ttl_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ttl_pkg::TTL_W-1:0]   ttl,
   ttl_req_if.sink                     req_chan,
   ttl_rsp_if.source                   rsp_chan,
   output ttl_pkg::op_type             op,
   output ttl_pkg::tok_type            tok_src,
   input  ttl_pkg::tok_type            tok_tail
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_COMMIT = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   ttl_pkg::op_type              op_ff, op_in;
   ttl_pkg::tok_type             src_ff, src_in;
   logic                         hit_ff, hit_in;
   logic [ttl_pkg::COUNT_W-1:0]  res_count_ff, res_count_in;
   logic [ttl_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ttl_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [ttl_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ttl_pkg::TIME_W:0]     expiry_sum;

   assign expiry_sum = {1'b0, req_chan.current_time} + {2'b00, ttl};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      src_in        = '0;
      hit_in        = hit_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in.cmd    = req_chan.cmd;
               op_in.key    = req_chan.token_key;
               op_in.now    = req_chan.current_time;
               op_in.expiry = expiry_sum[ttl_pkg::TIME_W] ? ttl_pkg::TIME_MAX
                                                          : expiry_sum[ttl_pkg::TIME_W-1:0];
               src_in.valid = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok_tail.valid) begin
               hit_in        = tok_tail.flag;
               src_in.valid  = 1'b1;
               src_in.commit = 1'b1;
               src_in.flag   = (op_ff.cmd == ttl_pkg::CMD_GENERATE) && !tok_tail.flag;
               state_in      = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (tok_tail.valid) begin
               res_count_in = tok_tail.count;
               if (op_ff.cmd == ttl_pkg::CMD_GENERATE && tok_tail.flag) begin
                  res_status_in = ttl_pkg::STATUS_FULL;
               end else if (op_ff.cmd == ttl_pkg::CMD_RENEW && !hit_ff) begin
                  res_status_in = ttl_pkg::STATUS_RENEW_MISS;
               end else begin
                  res_status_in = ttl_pkg::STATUS_DONE;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = res_count_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff.valid <= src_in.valid;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      src_ff.commit <= src_in.commit;
      src_ff.flag   <= src_in.flag;
      src_ff.count  <= src_in.count;
      hit_ff        <= hit_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.live_count = rsp_count_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign op                  = op_ff;
   assign tok_src             = src_ff;

   a_tail_in_pass: assert property (@(posedge clock) disable iff (reset)
      tok_tail.valid |-> (state_ff == ST_SCAN || state_ff == ST_COMMIT))
      else $error("token left the chain outside a pass");

   a_scan_tail_kind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && tok_tail.valid) |-> !tok_tail.commit)
      else $error("commit token seen during scan pass");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_SCAN && src_ff.valid))
      else $error("accepted item did not launch a scan token");

   a_launch_single: assert property (@(posedge clock) disable iff (reset)
      src_ff.valid |=> !src_ff.valid)
      else $error("token launched on two cycles in a row");

endmodule

// ===== hw/rtl/ttl_token_table_top.sv =====
// Top level of the token expiry table: time-to-live register, the chain of
// table cells and the sequencer. Depends on ttl_pkg, ttl_req_if, ttl_rsp_if,
// ttl_cell and ttl_ctrl.
//
// The table is a row of TABLE_ENTRIES cells, one entry each. An accepted item
// sends a token down the row twice, one cell per cycle: the first pass clears
// expired entries and refreshes a live matching key on generate or renew, the
// second inserts a new key into the lowest free entry and counts live entries.
// Items are taken only in idle. A result waits in the output register; the
// next item waits in finish while that register is full. live_count saturates
// at 127. The time-to-live register resets to 5; csr_wr_en/csr_wr_data write
// it, which the user does only while the table is idle; the block never checks.
module ttl_token_table_top #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [ttl_pkg::TTL_W-1:0] csr_wr_data,
   ttl_req_if.sink                   req_chan,
   ttl_rsp_if.source                 rsp_chan
);

   logic [ttl_pkg::TTL_W-1:0] ttl_ff, ttl_in;
   ttl_pkg::op_type           op;
   ttl_pkg::tok_type          chain_tok [0:TABLE_ENTRIES];

   always_comb begin
      ttl_in = ttl_ff;
      if (csr_wr_en) begin
         ttl_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= ttl_pkg::TTL_RESET;
      end else begin
         ttl_ff <= ttl_in;
      end
   end

   ttl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .ttl      (ttl_ff),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .op       (op),
      .tok_src  (chain_tok[0]),
      .tok_tail (chain_tok[TABLE_ENTRIES])
   );

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      ttl_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .op      (op),
         .tok_in  (chain_tok[g]),
         .tok_out (chain_tok[g+1])
      );
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for ttl_token_table_top: directed and random request traffic with a
// table predictor, response checking and random idling on both channels.
// Depends on ttl_pkg, ttl_req_if, ttl_rsp_if and ttl_token_table_top.
module tb_top;

   localparam int TBL_DEPTH   = 64;
   localparam int STALL_LIMIT = 4000;
   localparam logic [ttl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [ttl_pkg::TTL_W-1:0] TTL_TOP    = '1;

   typedef struct packed {
      logic [ttl_pkg::COUNT_W-1:0]  live_count;
      logic [ttl_pkg::STATUS_W-1:0] status;
   } table_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wr_en = 1'b0;
   logic [ttl_pkg::TTL_W-1:0]   csr_wr_data = '0;

   ttl_req_if req_bus ();
   ttl_rsp_if rsp_bus ();

   ttl_token_table_top #(
      .TABLE_ENTRIES(TBL_DEPTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   // table shadow
   logic                        ent_live   [TBL_DEPTH];
   logic [ttl_pkg::KEY_W-1:0]   ent_key    [TBL_DEPTH];
   logic [ttl_pkg::TIME_W-1:0]  ent_expiry [TBL_DEPTH];
   logic [ttl_pkg::TTL_W-1:0]   ttl_shadow = ttl_pkg::TTL_RESET;

   table_result_type    expected_results[$];
   int                  err_count = 0;
   int                  idle_cycles = 0;
   bit                  req_idle_on = 1'b1;
   bit                  rsp_idle_on = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   function automatic table_result_type predict_table_op(
         input logic [ttl_pkg::CMD_W-1:0]  op,
         input logic [ttl_pkg::KEY_W-1:0]  key,
         input logic [ttl_pkg::TIME_W-1:0] now);
      int                         hit;
      int                         free_idx;
      int                         live;
      logic [ttl_pkg::TIME_W:0]   sum;
      logic [ttl_pkg::TIME_W-1:0] new_exp;
      table_result_type           res;
      hit = -1;
      free_idx = -1;
      live = 0;
      sum = {1'b0, now} + {2'b00, ttl_shadow};
      new_exp = sum[ttl_pkg::TIME_W] ? ttl_pkg::TIME_MAX : sum[ttl_pkg::TIME_W-1:0];
      res.status = ttl_pkg::STATUS_DONE;
      for (int i = 0; i < TBL_DEPTH; i++) begin
         if (ent_live[i] && ent_expiry[i] <= now)
            ent_live[i] = 1'b0;
         if (ent_live[i]) begin
            if (hit < 0 && ent_key[i] == key)
               hit = i;
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      case (op)
         ttl_pkg::CMD_GENERATE: begin
            if (hit >= 0) begin
               ent_expiry[hit] = new_exp;
            end else if (free_idx >= 0) begin
               ent_live[free_idx] = 1'b1;
               ent_key[free_idx] = key;
               ent_expiry[free_idx] = new_exp;
            end else begin
               res.status = ttl_pkg::STATUS_FULL;
            end
         end
         ttl_pkg::CMD_RENEW: begin
            if (hit >= 0)
               ent_expiry[hit] = new_exp;
            else
               res.status = ttl_pkg::STATUS_RENEW_MISS;
         end
         default: ;
      endcase
      for (int i = 0; i < TBL_DEPTH; i++) begin
         if (ent_live[i] && ent_expiry[i] > now)
            live++;
      end
      if (live > ttl_pkg::COUNT_MAX)
         live = ttl_pkg::COUNT_MAX;
      res.live_count = live[ttl_pkg::COUNT_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("tb_top: mismatch at %0t: %0s", $time, msg);
      err_count++;
   endtask

   task automatic send_item(input logic [ttl_pkg::CMD_W-1:0]  op,
                            input logic [ttl_pkg::KEY_W-1:0]  key,
                            input logic [ttl_pkg::TIME_W-1:0] now);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.cmd = op;
      req_bus.token_key = key;
      req_bus.current_time = now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_results.push_back(predict_table_op(op, key, now));
   endtask

   task automatic drain_table();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_ttl(input logic [ttl_pkg::TTL_W-1:0] value);
      drain_table();
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      ttl_shadow = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [ttl_pkg::KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   task automatic test_basic_ops();
      send_item(ttl_pkg::CMD_GENERATE, 64'h0, 32'd100);
      send_item(ttl_pkg::CMD_GENERATE, '1, 32'd101);
      send_item(ttl_pkg::CMD_RENEW, 64'h0, 32'd103);
      send_item(ttl_pkg::CMD_COUNT, 64'h0, 32'd105);
      send_item(ttl_pkg::CMD_COUNT, '1, 32'd106);
      send_item(ttl_pkg::CMD_RENEW, '1, 32'd106);
      send_item(CMD_UNUSED, 64'h0, 32'd107);
   endtask

   task automatic test_duplicate_generate();
      send_item(ttl_pkg::CMD_GENERATE, 64'hA5A5_5A5A_0F0F_F0F0, 32'd200);
      send_item(ttl_pkg::CMD_GENERATE, 64'hA5A5_5A5A_0F0F_F0F0, 32'd200);
      write_ttl(31'd1);
      send_item(ttl_pkg::CMD_GENERATE, 64'h5A5A_A5A5_F0F0_0F0F, 32'd201);
      send_item(ttl_pkg::CMD_COUNT, 64'h0, 32'd201);
      send_item(ttl_pkg::CMD_COUNT, 64'h0, 32'd202);
   endtask

   task automatic test_zero_lifetime();
      write_ttl(31'd0);
      send_item(ttl_pkg::CMD_GENERATE, 64'h1234_5678_9ABC_DEF0, 32'd300);
      send_item(ttl_pkg::CMD_RENEW, 64'h1234_5678_9ABC_DEF0, 32'd300);
      send_item(ttl_pkg::CMD_COUNT, 64'h0, 32'd301);
   endtask

   task automatic test_expiry_cap();
      write_ttl(TTL_TOP);
      send_item(ttl_pkg::CMD_GENERATE, 64'h8000_0000_0000_0001, 32'h8000_0000);
      send_item(ttl_pkg::CMD_GENERATE, 64'h7FFF_FFFF_FFFF_FFFE, 32'hFFFF_FF00);
      send_item(ttl_pkg::CMD_COUNT, 64'h0, 32'hFFFF_FFFE);
      send_item(ttl_pkg::CMD_COUNT, 64'h0, ttl_pkg::TIME_MAX);
      send_item(ttl_pkg::CMD_GENERATE, 64'hFFFF_0000_FFFF_0000, ttl_pkg::TIME_MAX);
      send_item(ttl_pkg::CMD_COUNT, 64'h0, 32'd10);
   endtask

   task automatic test_fill_table();
      logic [ttl_pkg::KEY_W-1:0] last_key;
      write_ttl(31'd100000);
      last_key = '0;
      for (int i = 0; i < TBL_DEPTH + 2; i++) begin
         last_key = rand_key();
         send_item(ttl_pkg::CMD_GENERATE, last_key, 32'd1000 + i);
      end
      send_item(ttl_pkg::CMD_RENEW, last_key, 32'd1100);
      send_item(ttl_pkg::CMD_COUNT, 64'h0, 32'd1101);
   endtask

   task automatic test_random_traffic();
      logic [ttl_pkg::KEY_W-1:0]  key_pool [16];
      logic [ttl_pkg::KEY_W-1:0]  key;
      logic [ttl_pkg::CMD_W-1:0]  op;
      logic [ttl_pkg::TIME_W-1:0] now;
      logic [ttl_pkg::TIME_W-1:0] step;
      logic [ttl_pkg::TIME_W-1:0] step_max;
      int total;
      int phase;
      int count;
      int gen_pct;
      int fresh_pct;
      int r;
      total = 0;
      phase = 0;
      while (total < 1130) begin
         gen_pct = 40;
         fresh_pct = 20;
         now = $urandom_range(0, 1000);
         case (phase % 6)
            0: begin
               write_ttl(ttl_pkg::TTL_W'($urandom_range(1, 8)));
               step_max = 3;
            end
            1: begin
               write_ttl(31'd1000000);
               step_max = 2;
               gen_pct = 85;
               fresh_pct = 90;
            end
            2: begin
               write_ttl(31'd0);
               step_max = 1;
            end
            3: begin
               write_ttl(TTL_TOP);
               now = 32'hFFFF_FF00 - $urandom_range(0, 2000);
               step_max = 40;
               fresh_pct = 50;
            end
            4: begin
               write_ttl(ttl_pkg::TTL_W'($urandom));
               now = $urandom;
               step_max = $urandom_range(0, 1 << 20);
               fresh_pct = 50;
            end
            default: begin
               write_ttl(ttl_pkg::TTL_W'($urandom_range(20, 200)));
               step_max = 20;
               fresh_pct = 30;
            end
         endcase
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 16; i++)
            key_pool[i] = rand_key();
         count = $urandom_range(60, 120);
         for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 5)
               op = CMD_UNUSED;
            else if (r < 5 + gen_pct)
               op = ttl_pkg::CMD_GENERATE;
            else if (r < 5 + gen_pct + (95 - gen_pct) * 2 / 3)
               op = ttl_pkg::CMD_RENEW;
            else
               op = ttl_pkg::CMD_COUNT;
            if ($urandom_range(0, 99) < fresh_pct) begin
               key = rand_key();
               key_pool[$urandom_range(0, 15)] = key;
            end else begin
               key = key_pool[$urandom_range(0, 15)];
            end
            if ($urandom_range(0, 99) < 3 && now >= 20) begin
               now = now - $urandom_range(0, 20);
            end else begin
               step = $urandom_range(0, step_max);
               if (ttl_pkg::TIME_MAX - now < step)
                  now = ttl_pkg::TIME_MAX;
               else
                  now = now + step;
            end
            send_item(op, key, now);
         end
         total += count;
         phase++;
      end
   endtask

   // response side: stall, then hold ready until an item is taken
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = rsp_idle_on ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         @(posedge clock);
         while (!(rsp_bus.valid && rsp_bus.ready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected item count=%0d status=%0d",
                                      rsp_bus.live_count, rsp_bus.status));
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.live_count !== want.live_count)
               report_mismatch($sformatf("live_count got %0d expected %0d",
                                         rsp_bus.live_count, want.live_count));
            if (rsp_bus.status !== want.status)
               report_mismatch($sformatf("status got %0d expected %0d",
                                         rsp_bus.status, want.status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
         ent_live[i] = 1'b0;
         ent_key[i] = '0;
         ent_expiry[i] = '0;
      end
      req_bus.valid = 1'b0;
      req_bus.cmd = ttl_pkg::CMD_GENERATE;
      req_bus.token_key = '0;
      req_bus.current_time = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_duplicate_generate();
      test_zero_lifetime();
      test_expiry_cap();
      test_fill_table();
      test_random_traffic();

      drain_table();
      repeat (2 * TBL_DEPTH + 8) @(posedge clock);
      if (err_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
